/* hw/rtl/ppwe_pkg.sv */
package ppwe_pkg;

   // request type codes
   localparam logic [1:0] REQ_SET_COLOR   = 2'd0;
   localparam logic [1:0] REQ_DRAW_MAPPED = 2'd1;
   localparam logic [1:0] REQ_DRAW_RAW    = 2'd2;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIRTUAL_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIRTUAL_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_PITCH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_LAYOUT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GREEN_LAYOUT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLUE_LAYOUT    = 3'd6;

   // register reset values
   localparam logic [2:0]  RST_PIXEL_BYTES    = 3'd4;
   localparam logic [12:0] RST_VIRTUAL_WIDTH  = 13'd800;
   localparam logic [12:0] RST_VIRTUAL_HEIGHT = 13'd480;
   localparam logic [15:0] RST_LINE_PITCH     = 16'd3200;
   localparam logic [8:0]  RST_RED_LAYOUT     = 9'd272;
   localparam logic [8:0]  RST_GREEN_LAYOUT   = 9'd264;
   localparam logic [8:0]  RST_BLUE_LAYOUT    = 9'd256;

   localparam int unsigned ADDR_W  = 28;
   localparam int unsigned COLOR_W = 32;
   localparam logic [3:0]  CHAN_MAX_LEN = 4'd8;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic [7:0]         color_index;
      logic [23:0]        rgb_value;
      logic [30:0]        raw_color;
      logic               xor_request;
   } ppwe_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  byte_address;
      logic [COLOR_W-1:0] write_data;
      logic [2:0]         write_bytes;
      logic               xor_write;
   } ppwe_rsp_type;

   typedef struct packed {
      logic [2:0]  pixel_bytes;
      logic [12:0] virtual_width;
      logic [12:0] virtual_height;
      logic [15:0] line_pitch;
      logic [8:0]  red_layout;
      logic [8:0]  green_layout;
      logic [8:0]  blue_layout;
   } ppwe_cfg_type;

   // cut one 8-bit channel to its length and move it to its offset
   function automatic logic [COLOR_W-1:0] place_channel(input logic [7:0] chan,
                                                        input logic [8:0] layout);
      logic [3:0] len;
      logic [3:0] cut_sh;
      logic [7:0] cut;
      len    = (layout[8:5] > CHAN_MAX_LEN) ? CHAN_MAX_LEN : layout[8:5];
      cut_sh = CHAN_MAX_LEN - len;
      cut    = chan >> cut_sh;
      return {24'd0, cut} << layout[4:0];
   endfunction

   function automatic logic is_packing(input logic [2:0] pixel_bytes);
      return (pixel_bytes == 3'd2) || (pixel_bytes == 3'd4);
   endfunction

endpackage

/* hw/rtl/ppwe_csr.sv */
module ppwe_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppwe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppwe_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ppwe_pkg::ppwe_cfg_type               cfg
);

   ppwe_pkg::ppwe_cfg_type cfg_ff;
   logic                   wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_bytes    <= ppwe_pkg::RST_PIXEL_BYTES;
         cfg_ff.virtual_width  <= ppwe_pkg::RST_VIRTUAL_WIDTH;
         cfg_ff.virtual_height <= ppwe_pkg::RST_VIRTUAL_HEIGHT;
         cfg_ff.line_pitch     <= ppwe_pkg::RST_LINE_PITCH;
         cfg_ff.red_layout     <= ppwe_pkg::RST_RED_LAYOUT;
         cfg_ff.green_layout   <= ppwe_pkg::RST_GREEN_LAYOUT;
         cfg_ff.blue_layout    <= ppwe_pkg::RST_BLUE_LAYOUT;
      end else if (wr_en) begin
         case (csr_index)
            ppwe_pkg::CSR_PIXEL_BYTES:    cfg_ff.pixel_bytes    <= csr_wdata[2:0];
            ppwe_pkg::CSR_VIRTUAL_WIDTH:  cfg_ff.virtual_width  <= csr_wdata[12:0];
            ppwe_pkg::CSR_VIRTUAL_HEIGHT: cfg_ff.virtual_height <= csr_wdata[12:0];
            ppwe_pkg::CSR_LINE_PITCH:     cfg_ff.line_pitch     <= csr_wdata;
            ppwe_pkg::CSR_RED_LAYOUT:     cfg_ff.red_layout     <= csr_wdata[8:0];
            ppwe_pkg::CSR_GREEN_LAYOUT:   cfg_ff.green_layout   <= csr_wdata[8:0];
            ppwe_pkg::CSR_BLUE_LAYOUT:    cfg_ff.blue_layout    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

endmodule

/* hw/rtl/ppwe_cmap.sv */
module ppwe_cmap #(
   parameter int unsigned MAP_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppwe_pkg::ppwe_cfg_type               cfg,
   input  logic                                 wr_en,
   input  logic                                 rd_en,
   input  logic [7:0]                           color_index,
   input  logic [23:0]                          rgb_value,
   output logic [ppwe_pkg::COLOR_W-1:0]         rd_color
);

   localparam int unsigned IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   logic [ppwe_pkg::COLOR_W-1:0] map_mem [MAP_DEPTH];
   logic [MAP_DEPTH-1:0]         map_vld_ff;
   logic [ppwe_pkg::COLOR_W-1:0] rd_data_ff;
   logic                         rd_hit_ff;
   logic                         in_range;
   logic [IDX_W-1:0]             idx;
   logic [ppwe_pkg::COLOR_W-1:0] entry;

   assign in_range = {1'b0, color_index} < 9'(MAP_DEPTH);
   assign idx      = color_index[IDX_W-1:0];

   always_comb begin
      if (ppwe_pkg::is_packing(cfg.pixel_bytes)) begin
         entry = ppwe_pkg::place_channel(rgb_value[23:16], cfg.red_layout)
               | ppwe_pkg::place_channel(rgb_value[15:8], cfg.green_layout)
               | ppwe_pkg::place_channel(rgb_value[7:0], cfg.blue_layout);
      end else begin
         entry = {24'd0, color_index};
      end
   end

   // entries never written read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (wr_en && in_range) begin
         map_vld_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         map_mem[idx] <= entry;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[idx];
         rd_hit_ff  <= in_range && map_vld_ff[idx];
      end
   end

   assign rd_color = rd_hit_ff ? rd_data_ff : '0;

endmodule

/* hw/rtl/ppwe_wcmd.sv */
module ppwe_wcmd #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppwe_pkg::ppwe_cfg_type               cfg,
   input  logic                                 advance,
   input  logic                                 s1_valid,
   input  ppwe_pkg::ppwe_req_type               s1_req,
   input  logic [ppwe_pkg::COLOR_W-1:0]         map_color,
   output logic                                 rsp_valid,
   output ppwe_pkg::ppwe_rsp_type               rsp_data
);

   logic                         x_neg;
   logic                         y_neg;
   logic [15:0]                  x_mag;
   logic [15:0]                  y_mag;
   logic                         in_view;
   logic [31:0]                  y_prod;
   logic [18:0]                  x_prod;
   logic [31:0]                  addr_sum;
   logic [ppwe_pkg::COLOR_W-1:0] color;
   ppwe_pkg::ppwe_rsp_type       rsp_in;
   logic                         rsp_valid_in;
   logic                         rsp_valid_ff;
   ppwe_pkg::ppwe_rsp_type       rsp_data_ff;

   assign x_neg  = s1_req.x_pos[COORD_BITS-1];
   assign y_neg  = s1_req.y_pos[COORD_BITS-1];
   assign x_mag  = 16'(s1_req.x_pos[COORD_BITS-2:0]);
   assign y_mag  = 16'(s1_req.y_pos[COORD_BITS-2:0]);
   assign in_view = !x_neg && !y_neg
                 && (x_mag < {3'd0, cfg.virtual_width})
                 && (y_mag < {3'd0, cfg.virtual_height});

   assign y_prod   = y_mag * cfg.line_pitch;
   assign x_prod   = x_mag * cfg.pixel_bytes;
   assign addr_sum = y_prod + {13'd0, x_prod};

   always_comb begin
      if (s1_req.req_type == ppwe_pkg::REQ_DRAW_MAPPED) begin
         color = map_color;
      end else begin
         color = {1'b0, s1_req.raw_color};
      end
      rsp_in.byte_address = addr_sum[ppwe_pkg::ADDR_W-1:0];
      rsp_in.xor_write    = s1_req.xor_request;
      case (cfg.pixel_bytes)
         3'd2: begin
            rsp_in.write_bytes = 3'd2;
            rsp_in.write_data  = {16'd0, color[15:0]};
         end
         3'd4: begin
            rsp_in.write_bytes = 3'd4;
            rsp_in.write_data  = color;
         end
         default: begin
            rsp_in.write_bytes = 3'd1;
            rsp_in.write_data  = {24'd0, color[7:0]};
         end
      endcase
   end

   assign rsp_valid_in = s1_valid && in_view;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/palette_pixel_write_engine.sv */
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | ppwe_req_type: set colour or draw
// rsp     | out       | rsp_valid/rsp_stall | ppwe_rsp_type: framebuffer write
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// one item a cycle unless stalled; a draw inside passes stage one and the output register
// stage one registers the request and the colour map read port, stage two does
// clipping, y*pitch multiply and data trimming into the output register
// reset is synchronous; the colour map valid bits clear at once, no clearing pass
// rsp_stall holds only full stages; req_stall rises only when stage one is full and blocked
module palette_pixel_write_engine #(
   parameter int unsigned MAP_DEPTH  = 256,
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ppwe_pkg::ppwe_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ppwe_pkg::ppwe_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppwe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppwe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ppwe_pkg::ppwe_cfg_type       cfg;
   logic                         req_xfer;
   logic                         is_draw;
   logic                         is_set;
   logic                         out_free;
   logic                         s1_free;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   ppwe_pkg::ppwe_req_type       s1_req_ff;
   logic [ppwe_pkg::COLOR_W-1:0] map_color;

   // output register moves when empty or when its result is taken
   assign out_free  = !rsp_valid || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign req_xfer  = req_valid && !req_stall;

   assign is_set  = req_data.req_type == ppwe_pkg::REQ_SET_COLOR;
   assign is_draw = (req_data.req_type == ppwe_pkg::REQ_DRAW_MAPPED)
                 || (req_data.req_type == ppwe_pkg::REQ_DRAW_RAW);

   // only draws occupy stage one; sets write the map on their transfer,
   // so a draw right behind a set already sees the new entry
   assign s1_valid_in = req_xfer && is_draw;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_req_ff <= req_data;
      end
   end

   ppwe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // read data only loads on a transfer, so it holds while stage one waits
   ppwe_cmap #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_cmap (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .wr_en       (req_xfer && is_set),
      .rd_en       (req_xfer),
      .color_index (req_data.color_index),
      .rgb_value   (req_data.rgb_value),
      .rd_color    (map_color)
   );

   ppwe_wcmd #(
      .COORD_BITS (COORD_BITS)
   ) u_wcmd (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (out_free),
      .s1_valid  (s1_valid_ff),
      .s1_req    (s1_req_ff),
      .map_color (map_color),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/ppwe_checker.sv */
module ppwe_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ppwe_pkg::ppwe_rsp_type rsp_data
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_width_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.write_bytes == 3'd1) || (rsp_data.write_bytes == 3'd2)
                 || (rsp_data.write_bytes == 3'd4))
      else $error("illegal write width");

   a_data_trimmed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.write_bytes != 3'd1) || (rsp_data.write_data[31:8] == 24'd0))
                 && ((rsp_data.write_bytes != 3'd2) || (rsp_data.write_data[31:16] == 16'd0)))
      else $error("write data wider than write width");

endmodule

bind palette_pixel_write_engine ppwe_checker u_ppwe_checker (.*);
